// ===== rtl/core/pcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and constants of the PNG chunk deframer.
// ----------------------------------------------------------------------------
package pcd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned ERR_W     = 3;
    localparam int unsigned TDATA_W   = 104;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SUPPORTED_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_FIRST      = 3'd1;

    // Record kinds
    localparam logic [KIND_W-1:0] KIND_CHUNK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_SHORT_SIG = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_SIG   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_SHORT_HDR = 3'd3;
    localparam logic [ERR_W-1:0] ERR_OVERRUN   = 3'd4;
    localparam logic [ERR_W-1:0] ERR_BAD_NAME  = 3'd5;

    localparam logic [2:0]        SIG_LAST  = 3'd7;
    localparam logic [1:0]        FIELD_END = 2'd3;
    localparam logic [3:0]        HDR_MIN   = 4'd12;
    localparam int unsigned       CASE_BIT  = 5;
    localparam logic [WORD_W-1:0] OFF_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] name;
        logic [WORD_W-1:0] length;
        logic [WORD_W-1:0] offset;
        logic              crit;
        logic              sup;
        logic [ERR_W-1:0]  err;
    } rec_t;

    // Results caused by one byte: an optional record, then an optional done record
    typedef struct packed {
        logic rec_vld;
        logic done_vld;
        rec_t rec;
    } bundle_t;

    localparam rec_t DONE_REC = '{kind: KIND_DONE, name: '0, length: '0, offset: '0,
                                  crit: 1'b0, sup: 1'b0, err: ERR_NONE};

    function automatic logic [BYTE_W-1:0] sig_byte(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/pcd_name_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_name_match
// Supported-name registers on the config port and the name lookup.
// ----------------------------------------------------------------------------
module pcd_name_match
    import pcd_pkg::*;
#(
    parameter int unsigned SUPPORTED_SLOTS = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic [WORD_W-1:0]    name,
    output logic                 supported
);

    logic [CFG_IDX_W-1:0] count_reg;
    logic [WORD_W-1:0]    slot_reg [SUPPORTED_SLOTS];
    logic [CFG_IDX_W-1:0] eff_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int i = 0; i < SUPPORTED_SLOTS; i++) begin
                slot_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            if (cfg_index == REG_SUPPORTED_COUNT) begin
                count_reg <= cfg_data[CFG_IDX_W-1:0];
            end
            for (int i = 0; i < SUPPORTED_SLOTS; i++) begin
                if (cfg_index == REG_NAME_FIRST + CFG_IDX_W'(i)) begin
                    slot_reg[i] <= cfg_data;
                end
            end
        end
    end

    // counts above the slot count use every slot
    assign eff_count = (count_reg > CFG_IDX_W'(SUPPORTED_SLOTS)) ?
                       CFG_IDX_W'(SUPPORTED_SLOTS) : count_reg;

    always_comb begin
        supported = 1'b0;
        for (int i = 0; i < SUPPORTED_SLOTS; i++) begin
            if ((CFG_IDX_W'(i) < eff_count) && (slot_reg[i] == name)) begin
                supported = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/pcd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_parser
// Per-byte framing state: signature check, chunk header, data and CRC skip.
// ----------------------------------------------------------------------------
module pcd_parser
    import pcd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              beat,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    input  logic              supported,
    output logic [WORD_W-1:0] cur_name,
    output bundle_t           bundle
);

    typedef enum logic [2:0] {
        PH_SIG,
        PH_LEN,
        PH_NAME,
        PH_DATA,
        PH_CRC
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [2:0]        pos_reg, pos_next;
    logic [WORD_W-1:0] length_reg, length_next;
    logic [WORD_W-1:0] name_reg, name_next;
    logic [WORD_W-1:0] left_reg, left_next;
    logic [WORD_W-1:0] offset_reg, offset_next;
    logic [WORD_W-1:0] start_reg, start_next;
    logic [3:0]        hdr_reg, hdr_next;
    logic              sig_bad_reg, sig_bad_next;
    logic              err_reg, err_next;

    logic              sig_bad_now;
    logic              complete;
    logic [WORD_W-1:0] off_inc;
    logic [3:0]        hdr_inc;

    assign cur_name    = name_reg;
    assign sig_bad_now = sig_bad_reg | (in_byte != sig_byte(pos_reg));
    assign off_inc     = (offset_reg == OFF_MAX) ? offset_reg : offset_reg + 1'b1;
    assign hdr_inc     = (hdr_reg < HDR_MIN) ? hdr_reg + 1'b1 : hdr_reg;

    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        length_next  = length_reg;
        name_next    = name_reg;
        left_next    = left_reg;
        offset_next  = offset_reg;
        start_next   = start_reg;
        hdr_next     = hdr_reg;
        sig_bad_next = sig_bad_reg;
        err_next     = err_reg;
        complete     = 1'b0;
        bundle       = '0;

        if (beat && !err_reg) begin
            offset_next = off_inc;
            unique case (phase_reg)
                PH_SIG: begin
                    sig_bad_next = sig_bad_now;
                    pos_next     = pos_reg + 1'b1;
                    if (pos_reg == SIG_LAST) begin
                        if (sig_bad_now) begin
                            bundle.rec_vld  = 1'b1;
                            bundle.rec.kind = KIND_ERROR;
                            bundle.rec.err  = ERR_BAD_SIG;
                            err_next        = 1'b1;
                        end else begin
                            phase_next      = PH_LEN;
                            pos_next        = '0;
                            length_next     = '0;
                            name_next       = '0;
                            left_next       = '0;
                            hdr_next        = '0;
                            bundle.done_vld = in_last;
                        end
                    end else if (in_last) begin
                        bundle.rec_vld  = 1'b1;
                        bundle.rec.kind = KIND_ERROR;
                        bundle.rec.err  = ERR_SHORT_SIG;
                    end
                end
                PH_LEN: begin
                    hdr_next    = hdr_inc;
                    length_next = {length_reg[WORD_W-BYTE_W-1:0], in_byte};
                    pos_next    = pos_reg + 1'b1;
                    if (pos_reg[1:0] == FIELD_END) begin
                        phase_next = PH_NAME;
                        pos_next   = '0;
                    end
                end
                PH_NAME: begin
                    hdr_next = hdr_inc;
                    // first name byte lands in the low bits
                    name_next[pos_reg[1:0]*BYTE_W +: BYTE_W] = in_byte;
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg[1:0] == FIELD_END) begin
                        start_next = off_inc;
                        pos_next   = '0;
                        if (length_reg == '0) begin
                            phase_next = PH_CRC;
                        end else begin
                            phase_next = PH_DATA;
                            left_next  = length_reg;
                        end
                    end
                end
                PH_DATA: begin
                    hdr_next  = hdr_inc;
                    left_next = left_reg - 1'b1;
                    if (left_reg == WORD_W'(1)) begin
                        phase_next = PH_CRC;
                        pos_next   = '0;
                    end
                end
                PH_CRC: begin
                    hdr_next = hdr_inc;
                    pos_next = pos_reg + 1'b1;
                    complete = (pos_reg[1:0] == FIELD_END);
                end
                default: begin
                    phase_next = PH_SIG;
                end
            endcase

            if (complete) begin
                bundle.rec_vld = 1'b1;
                if (name_reg[2*BYTE_W + CASE_BIT]) begin
                    bundle.rec.kind = KIND_ERROR;
                    bundle.rec.err  = ERR_BAD_NAME;
                    err_next        = 1'b1;
                end else begin
                    bundle.rec.kind   = KIND_CHUNK;
                    bundle.rec.name   = name_reg;
                    bundle.rec.length = length_reg;
                    bundle.rec.offset = start_reg;
                    bundle.rec.crit   = ~name_reg[CASE_BIT];
                    bundle.rec.sup    = supported;
                    bundle.rec.err    = ERR_NONE;
                    bundle.done_vld   = in_last;
                    phase_next        = PH_LEN;
                    pos_next          = '0;
                    length_next       = '0;
                    name_next         = '0;
                    left_next         = '0;
                    hdr_next          = '0;
                end
            end else if (in_last && (phase_reg != PH_SIG)) begin
                bundle.rec_vld  = 1'b1;
                bundle.rec.kind = KIND_ERROR;
                bundle.rec.err  = (hdr_inc < HDR_MIN) ? ERR_SHORT_HDR : ERR_OVERRUN;
            end
        end

        // final byte always returns to the post-reset state
        if (beat && in_last) begin
            phase_next   = PH_SIG;
            pos_next     = '0;
            length_next  = '0;
            name_next    = '0;
            left_next    = '0;
            offset_next  = '0;
            start_next   = '0;
            hdr_next     = '0;
            sig_bad_next = 1'b0;
            err_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIG;
            pos_reg     <= '0;
            length_reg  <= '0;
            name_reg    <= '0;
            left_reg    <= '0;
            offset_reg  <= '0;
            start_reg   <= '0;
            hdr_reg     <= '0;
            sig_bad_reg <= 1'b0;
            err_reg     <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            length_reg  <= length_next;
            name_reg    <= name_next;
            left_reg    <= left_next;
            offset_reg  <= offset_next;
            start_reg   <= start_next;
            hdr_reg     <= hdr_next;
            sig_bad_reg <= sig_bad_next;
            err_reg     <= err_next;
        end
    end

    a_quiet_after_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat && err_reg) |-> (!bundle.rec_vld && !bundle.done_vld))
        else $error("result produced while error is latched");

    a_done_needs_last: assert property (@(posedge aclk) disable iff (!aresetn)
        bundle.done_vld |-> (beat && in_last))
        else $error("done record without final byte");

    a_hdr_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_reg <= HDR_MIN)
        else $error("header byte count past limit");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat && in_last) |=> (phase_reg == PH_SIG && pos_reg == '0 && !err_reg))
        else $error("final byte did not restart the parser");

endmodule

// ===== rtl/core/pcd_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_out_buf
// Result register: holds a record and an optional done record, sends them.
// ----------------------------------------------------------------------------
module pcd_out_buf
    import pcd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  bundle_t            bundle,
    output logic               free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]  m_tuser,
    output logic               m_tlast
);

    logic rec_vld_reg, rec_vld_next;
    logic done_vld_reg, done_vld_next;
    rec_t rec_reg;
    rec_t cur;
    logic pop;

    assign m_tvalid = rec_vld_reg | done_vld_reg;
    assign pop      = m_tvalid & m_tready;
    // room for a new pair once at most one beat is left and it goes out now
    assign free     = !m_tvalid || (m_tready && !(rec_vld_reg && done_vld_reg));

    assign cur     = rec_vld_reg ? rec_reg : DONE_REC;
    assign m_tuser = cur.kind;
    assign m_tdata = {3'b000, cur.err, cur.sup, cur.crit, cur.offset, cur.length, cur.name};
    assign m_tlast = !(rec_vld_reg && done_vld_reg);

    always_comb begin
        rec_vld_next  = rec_vld_reg;
        done_vld_next = done_vld_reg;
        if (pop) begin
            if (rec_vld_reg) begin
                rec_vld_next = 1'b0;
            end else begin
                done_vld_next = 1'b0;
            end
        end
        if (load) begin
            rec_vld_next  = bundle.rec_vld;
            done_vld_next = bundle.done_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_vld_reg  <= 1'b0;
            done_vld_reg <= 1'b0;
        end else begin
            rec_vld_reg  <= rec_vld_next;
            done_vld_reg <= done_vld_next;
        end
        if (load && bundle.rec_vld) begin
            rec_reg <= bundle.rec;
        end
    end

    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (rec_vld_reg && done_vld_reg) |-> !free)
        else $error("accepting while two results are pending");

    a_done_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (rec_vld_reg && done_vld_reg && m_tready) |=> (done_vld_reg && !rec_vld_reg))
        else $error("done record lost after chunk record");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !load)
        else $error("pending result overwritten");

endmodule

// ===== rtl/core/png_chunk_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_deframer_top
// PNG byte stream in, chunk / done / error records out.
// Latency: a record appears on m_* the cycle after its byte is accepted.
// Throughput: one byte per cycle while the record side keeps up; a final byte that
//   yields a chunk and a done record holds the result register until both have gone out.
// The output register pair sets the rate; the parser updates its state on every accepted byte.
// Reset (aresetn low, synchronous): parser back to signature phase, offset 0,
//   result register empty, supported count and names cleared.
// ----------------------------------------------------------------------------
module png_chunk_deframer_top
    import pcd_pkg::*;
#(
    parameter int unsigned SUPPORTED_SLOTS = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] file_byte
    input  logic                 s_tlast,   // final_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] chunk_name, [63:32] chunk_length, [95:64] data_offset,
    // [96] is_critical, [97] is_supported, [100:98] error_code, [103:101] zero
    output logic [TDATA_W-1:0]   m_tdata,
    output logic [KIND_W-1:0]    m_tuser,   // [1:0] record_kind
    output logic                 m_tlast,   // run_end
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic              beat;
    logic              supported;
    logic [WORD_W-1:0] cur_name;
    bundle_t           bundle;

    assign beat = s_tvalid & s_tready;

    pcd_name_match #(
        .SUPPORTED_SLOTS(SUPPORTED_SLOTS)
    ) u_match (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .name      (cur_name),
        .supported (supported)
    );

    pcd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat      (beat),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .supported (supported),
        .cur_name  (cur_name),
        .bundle    (bundle)
    );

    pcd_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (beat),
        .bundle   (bundle),
        .free     (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sim/png_chunk_deframer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_deframer_checker
// Watches the byte, record and register-write channels of the deframer. It
// tracks the parser state and the supported-name table on its own, works out
// the records each accepted byte must produce and compares every record beat
// against the oldest one still due.
// ----------------------------------------------------------------------------
module png_chunk_deframer_checker
    import pcd_pkg::*;
#(
    parameter int unsigned SUPPORTED_SLOTS = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] file_byte
    input  logic                 s_tlast,   // final_byte
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] chunk_name, [63:32] chunk_length, [95:64] data_offset,
    // [96] is_critical, [97] is_supported, [100:98] error_code, [103:101] zero
    input  logic [TDATA_W-1:0]   m_tdata,
    input  logic [KIND_W-1:0]    m_tuser,   // [1:0] record_kind
    input  logic                 m_tlast,   // run_end
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output logic [31:0]          fail_count,
    output logic [31:0]          records_pending,
    output logic [31:0]          live_bytes
);

    typedef enum logic [2:0] {ST_SIG, ST_LEN, ST_NAME, ST_DATA, ST_CRC} parse_state_t;

    typedef struct packed {
        rec_t rec;
        logic run_end;
    } rec_beat_t;

    localparam int unsigned NAME_SLOTS = 6;
    localparam int unsigned SIG_BYTES  = 8;
    localparam int unsigned FIELD_BYTES = 4;
    // signature, byte 0 in the low bits
    localparam logic [63:0] PNG_MAGIC = 64'h0A1A_0A0D_474E_5089;

    logic [2:0]        known_count;
    logic [WORD_W-1:0] known_names [NAME_SLOTS];

    parse_state_t      state;
    int unsigned       pos;
    int unsigned       hdr_seen;
    logic [WORD_W-1:0] hdr_len;
    logic [WORD_W-1:0] hdr_name;
    logic [WORD_W-1:0] data_left;
    logic [WORD_W-1:0] file_off;
    logic [WORD_W-1:0] data_start;
    logic              sig_bad;
    logic              err_latched;

    rec_beat_t due_records [$];
    int        fails = 0;
    int        live  = 0;
    int        pending = 0;

    assign fail_count      = fails;
    assign records_pending = pending;
    assign live_bytes      = live;

    function automatic logic [WORD_W-1:0] bump_sat(input logic [WORD_W-1:0] v);
        return (v == OFF_MAX) ? v : v + 1'b1;
    endfunction

    function automatic rec_t status_rec(input logic [KIND_W-1:0] kind,
                                        input logic [ERR_W-1:0] err);
        rec_t r;
        r = '0;
        r.kind = kind;
        r.err  = err;
        return r;
    endfunction

    function automatic logic name_known(input logic [WORD_W-1:0] nm);
        int unsigned n;
        logic        hit;
        n   = (known_count > SUPPORTED_SLOTS) ? SUPPORTED_SLOTS : known_count;
        hit = 1'b0;
        for (int i = 0; i < NAME_SLOTS; i++)
            if (i < n && known_names[i] == nm)
                hit = 1'b1;
        return hit;
    endfunction

    task automatic start_chunk();
        state     = ST_LEN;
        pos       = 0;
        hdr_len   = '0;
        hdr_name  = '0;
        data_left = '0;
        hdr_seen  = 0;
    endtask

    task automatic restart_file();
        start_chunk();
        state       = ST_SIG;
        file_off    = '0;
        data_start  = '0;
        sig_bad     = 1'b0;
        err_latched = 1'b0;
    endtask

    task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fails++;
        end
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic fin);
        logic [WORD_W-1:0] off;
        logic              complete;
        rec_t              recs [2];
        rec_beat_t         beat;
        int                n;
        complete = 1'b0;
        n        = 0;
        if (err_latched) begin
            // everything up to the end of the file is dropped
            if (fin)
                restart_file();
        end else begin
            live++;
            off      = file_off;
            file_off = bump_sat(file_off);
            if (state == ST_SIG) begin
                if (b != PNG_MAGIC[8*pos +: 8])
                    sig_bad = 1'b1;
                pos++;
                if (pos == SIG_BYTES) begin
                    if (sig_bad) begin
                        recs[n] = status_rec(KIND_ERROR, ERR_BAD_SIG);
                        n++;
                        err_latched = 1'b1;
                    end else begin
                        start_chunk();
                        if (fin) begin
                            recs[n] = DONE_REC;
                            n++;
                        end
                    end
                end else if (fin) begin
                    recs[n] = status_rec(KIND_ERROR, ERR_SHORT_SIG);
                    n++;
                end
            end else begin
                if (hdr_seen < HDR_MIN)
                    hdr_seen++;
                case (state)
                    ST_LEN: begin
                        hdr_len = {hdr_len[23:0], b};
                        pos++;
                        if (pos == FIELD_BYTES) begin
                            state = ST_NAME;
                            pos   = 0;
                        end
                    end
                    ST_NAME: begin
                        hdr_name[8*pos +: 8] = b;
                        pos++;
                        if (pos == FIELD_BYTES) begin
                            data_start = bump_sat(off);
                            pos        = 0;
                            if (hdr_len == 0) begin
                                state = ST_CRC;
                            end else begin
                                state     = ST_DATA;
                                data_left = hdr_len;
                            end
                        end
                    end
                    ST_DATA: begin
                        data_left = data_left - 1'b1;
                        if (data_left == 0) begin
                            state = ST_CRC;
                            pos   = 0;
                        end
                    end
                    default: begin
                        pos++;
                        if (pos == FIELD_BYTES)
                            complete = 1'b1;
                    end
                endcase

                if (complete) begin
                    // reserved bit lives in name byte 2
                    if (hdr_name[16 + CASE_BIT]) begin
                        recs[n] = status_rec(KIND_ERROR, ERR_BAD_NAME);
                        n++;
                        err_latched = 1'b1;
                    end else begin
                        recs[n]        = '0;
                        recs[n].kind   = KIND_CHUNK;
                        recs[n].name   = hdr_name;
                        recs[n].length = hdr_len;
                        recs[n].offset = data_start;
                        recs[n].crit   = ~hdr_name[CASE_BIT];
                        recs[n].sup    = name_known(hdr_name);
                        recs[n].err    = ERR_NONE;
                        n++;
                        start_chunk();
                        if (fin) begin
                            recs[n] = DONE_REC;
                            n++;
                        end
                    end
                end else if (fin) begin
                    recs[n] = status_rec(KIND_ERROR,
                                         (hdr_seen < HDR_MIN) ? ERR_SHORT_HDR : ERR_OVERRUN);
                    n++;
                end
            end
            if (fin)
                restart_file();
        end
        for (int i = 0; i < n; i++) begin
            beat.rec     = recs[i];
            beat.run_end = (i == n - 1);
            due_records.push_back(beat);
        end
    endtask

    always @(posedge aclk) begin : watch
        rec_beat_t want;
        if (!aresetn) begin
            known_count = '0;
            for (int i = 0; i < NAME_SLOTS; i++)
                known_names[i] = '0;
            restart_file();
            due_records.delete();
        end else begin
            // records are registered after their byte is accepted, so compare before predicting
            if (m_tvalid && m_tready) begin
                if (due_records.size() == 0) begin
                    $error("record_kind: expected none, got 0x%0h", m_tuser);
                    fails++;
                end else begin
                    want = due_records.pop_front();
                    check_field("record_kind", WORD_W'(want.rec.kind), WORD_W'(m_tuser));
                    check_field("chunk_name", want.rec.name, m_tdata[31:0]);
                    check_field("chunk_length", want.rec.length, m_tdata[63:32]);
                    check_field("data_offset", want.rec.offset, m_tdata[95:64]);
                    check_field("is_critical", WORD_W'(want.rec.crit), WORD_W'(m_tdata[96]));
                    check_field("is_supported", WORD_W'(want.rec.sup), WORD_W'(m_tdata[97]));
                    check_field("error_code", WORD_W'(want.rec.err),
                                WORD_W'(m_tdata[100:98]));
                    check_field("tdata_pad", '0, WORD_W'(m_tdata[103:101]));
                    check_field("run_end", WORD_W'(want.run_end), WORD_W'(m_tlast));
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SUPPORTED_COUNT)
                    known_count = cfg_data[2:0];
                else if (cfg_index >= REG_NAME_FIRST &&
                         cfg_index < REG_NAME_FIRST + NAME_SLOTS)
                    known_names[cfg_index - REG_NAME_FIRST] = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
        end
        pending = due_records.size();
    end

endmodule

// ===== sim/tb_png_chunk_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_png_chunk_deframer_top
// Feeds PNG-like byte streams into the deframer: a few hand-built files, then
// random files that are mostly well formed with random chunk contents, plus
// corrupted signatures, truncations, oversized lengths and reserved-bit names.
// The supported-name table is reloaded before each phase under several settings.
// Both stream sides idle at random; the record side also stalls for a long
// stretch once. The checker instance judges every record.
// ----------------------------------------------------------------------------
module tb_png_chunk_deframer_top;
    import pcd_pkg::*;

    localparam int unsigned SUPPORTED_SLOTS = 6;
    localparam int unsigned NAME_SLOTS      = 6;
    localparam int unsigned TARGET_BYTES    = 1450;
    localparam int unsigned PHASES          = 5;
    localparam int unsigned LONG_HOLD       = 300;
    localparam int unsigned SIG_BYTES       = 8;
    localparam logic [7:0]  LOWER_MASK      = 8'h20;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    logic [31:0] fail_count;
    logic [31:0] records_pending;
    logic [31:0] live_bytes;

    logic [BYTE_W-1:0] file_bytes [$];
    logic [WORD_W-1:0] name_slots [NAME_SLOTS];
    bit                calm       = 1'b0;
    int                hold_asks  = 0;
    int                holds_done = 0;

    png_chunk_deframer_top #(
        .SUPPORTED_SLOTS(SUPPORTED_SLOTS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    png_chunk_deframer_checker #(
        .SUPPORTED_SLOTS(SUPPORTED_SLOTS)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .records_pending (records_pending),
        .live_bytes      (live_bytes)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // record side: random backpressure, or one long hold when asked
    initial begin
        forever begin
            @(posedge aclk);
            if (holds_done != hold_asks) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 30);
            end
        end
    end

    function automatic logic [7:0] name_char(input bit lower);
        return (8'h41 + 8'($urandom_range(25))) | (lower ? LOWER_MASK : 8'h00);
    endfunction

    // byte 0 case picks critical/ancillary; byte 2 is rarely lowercase (reserved bit)
    function automatic logic [WORD_W-1:0] letter_name();
        logic [7:0] b0, b1, b2, b3;
        b0 = name_char($urandom_range(1) != 0);
        b1 = name_char($urandom_range(1) != 0);
        b2 = name_char($urandom_range(99) < 6);
        b3 = name_char($urandom_range(1) != 0);
        return {b3, b2, b1, b0};
    endfunction

    function automatic logic [WORD_W-1:0] pick_name();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35)
            return name_slots[$urandom_range(NAME_SLOTS - 1)];
        else if (r < 50)
            return $urandom();
        return letter_name();
    endfunction

    task automatic add_header(input logic [WORD_W-1:0] len, input logic [WORD_W-1:0] nm);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(len[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(nm[8*i +: 8]);
    endtask

    // header, data and a junk CRC
    task automatic add_chunk(input int unsigned len, input logic [WORD_W-1:0] nm);
        add_header(len, nm);
        repeat (len + 4)
            file_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic add_signature();
        for (int i = 0; i < SIG_BYTES; i++)
            file_bytes.push_back(sig_byte(3'(i)));
    endtask

    task automatic build_file();
        int unsigned       chunks;
        int unsigned       len;
        int unsigned       cut;
        int unsigned       r;
        logic [WORD_W-1:0] big;
        file_bytes.delete();
        add_signature();
        if ($urandom_range(99) < 6) begin
            cut = $urandom_range(SIG_BYTES - 1);
            file_bytes[cut] = file_bytes[cut] ^ (8'h01 << $urandom_range(7));
        end
        chunks = $urandom_range(3);
        repeat (chunks) begin
            r   = $urandom_range(99);
            len = (r < 70) ? $urandom_range(6) :
                  (r < 95) ? $urandom_range(24, 7) : $urandom_range(64, 25);
            add_chunk(len, pick_name());
        end
        r = $urandom_range(99);
        if (r < 6) begin
            // length far beyond the file: ends inside the header or the data
            big = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : ($urandom() | 32'h8000_0000);
            add_header(big, pick_name());
            repeat ($urandom_range(8))
                file_bytes.push_back(8'($urandom_range(255)));
        end else if (r < 18) begin
            cut = $urandom_range(file_bytes.size() - 1, 1);
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!calm && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    // wait until every record is out and the parser has had time to go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (records_pending != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input int p);
        logic [2:0] cnt;
        case (p)
            0:       cnt = '0;
            1:       cnt = 3'(SUPPORTED_SLOTS);
            2:       cnt = '1;  // more than there are slots
            3:       cnt = 3'd3;
            default: cnt = 3'($urandom_range(5, 1));
        endcase
        write_reg(REG_SUPPORTED_COUNT, WORD_W'(cnt));
        for (int i = 0; i < NAME_SLOTS; i++) begin
            name_slots[i] = letter_name();
            if (p == 1 && i == 0)
                name_slots[i] = '0;
            if (p == 1 && i == NAME_SLOTS - 1)
                name_slots[i] = '1;
            write_reg(REG_NAME_FIRST + 3'(i), name_slots[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned goal;
        for (int i = 0; i < NAME_SLOTS; i++)
            name_slots[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // file cut off on its first byte
        file_bytes.delete();
        file_bytes.push_back(sig_byte(3'd0));
        send_file();

        // wrong last signature byte, trailing bytes ignored
        file_bytes.delete();
        add_signature();
        file_bytes[SIG_BYTES - 1] = 8'hFF;
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h5A);
        send_file();

        // shortest complete file: one empty critical chunk, end on its CRC
        file_bytes.delete();
        add_signature();
        add_chunk(0, 32'h444E_4549);
        send_file();

        for (int p = 0; p < PHASES; p++) begin
            settle();
            configure(p);
            calm = (p == 2);
            if (p == 1)
                hold_asks++;
            goal = live_bytes + TARGET_BYTES / PHASES;
            while (live_bytes < goal) begin
                build_file();
                send_file();
            end
        end
        calm = 1'b0;
        settle();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
